/* hdl/nss_pkg.sv */
package nss_pkg;

   localparam int MaxSegments = 256;
   localparam int AddrWidth   = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
   localparam int CountWidth  = $clog2(MaxSegments + 1);
   localparam int CoordWidth  = 24;
   localparam int PointWidth  = 2 * CoordWidth;
   localparam int IndexWidth  = 8;
   localparam int TWidth      = 17;
   localparam int DistWidth   = 50;
   localparam int RootWidth   = 25;
   localparam logic [TWidth-1:0] TOne = TWidth'(65536);

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_LOADED = 3'd0,
      ST_FULL   = 3'd1,
      ST_FOUND  = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DIFF, S_PROD, S_SUM, S_DIV, S_MUL, S_NEAR, S_ESQ, S_CMP,
      S_ROOT, S_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic [DistWidth-1:0] value;
   } root_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [RootWidth-1:0] root;
   } root_stat_type;

endpackage

/* hdl/nss_if.sv */
interface nss_req_if;
   logic valid;
   logic ready;
   logic [1:0] op;
   logic signed [23:0] start_x;
   logic signed [23:0] start_z;
   logic signed [23:0] end_x;
   logic signed [23:0] end_z;
   logic signed [23:0] query_x;
   logic signed [23:0] query_z;
   modport source (output valid, op, start_x, start_z, end_x, end_z, query_x, query_z,
                   input ready);
   modport sink (input valid, op, start_x, start_z, end_x, end_z, query_x, query_z,
                 output ready);
endinterface

interface nss_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic signed [23:0] near_x;
   logic signed [23:0] near_z;
   logic [7:0] segment_index;
   logic [16:0] t_param;
   logic [49:0] dist_sq;
   logic [24:0] dist_res;
   modport source (output valid, status, near_x, near_z, segment_index, t_param, dist_sq,
                   dist_res, input ready);
   modport sink (input valid, status, near_x, near_z, segment_index, t_param, dist_sq,
                 dist_res, output ready);
endinterface

/* hdl/nss_ram.sv */
module nss_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/nss_root.sv */
// Bit-pair restoring square root, one result bit per cycle.
module nss_root (
   input  logic                  clock,
   input  logic                  reset,
   input  nss_pkg::root_req_type req,
   output nss_pkg::root_stat_type stat
);
   localparam int Steps = nss_pkg::DistWidth / 2;

   logic [nss_pkg::DistWidth-1:0] rem_ff, rem_in, val_ff, val_in;
   logic [nss_pkg::RootWidth-1:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [nss_pkg::DistWidth+1:0] trial;
   logic [nss_pkg::DistWidth+1:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, val_ff[nss_pkg::DistWidth-1 -: 2]};
      trial   = {{(nss_pkg::DistWidth+2-nss_pkg::RootWidth-2){1'b0}}, root_ff, 2'b01};
      if (req.start) begin
         rem_in  = '0;
         val_in  = req.value;
         root_in = '0;
         cnt_in  = 5'(Steps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[nss_pkg::DistWidth-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = nss_pkg::DistWidth'(shifted - trial);
            root_in = {root_ff[nss_pkg::RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = nss_pkg::DistWidth'(shifted);
            root_in = {root_ff[nss_pkg::RootWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.root = root_ff;
endmodule

/* hdl/nearest_segment_snap.sv */
// Nearest point on a stored set of up to 256 segments. Append (op 0) writes
// both endpoints into two single-port-write RAMs. Clear (op 2) resets the fill
// count. Append, clear and a query on an empty table load the result register
// at the accepting edge, so the result is valid in the next cycle. A query
// (op 1) walks the table one segment at a time. Each segment takes a RAM read,
// the differences, the products, the sums, a restoring divide for t (a clamp
// check, then 16 quotient bits), the snapped point, the squared error and a
// compare; the quotient bits are skipped when t clamps to 0 or 1.0 or the
// segment has zero length. A square root of the best distance follows, and
// the root is loaded into the result register. The result is held in a
// register until taken, and no new request is taken while a result waits or
// a query is running. Ties keep the segment loaded first; a full-table append
// returns status 1.
module nearest_segment_snap (
   input logic clock,
   input logic reset,
   nss_req_if.sink   req,
   nss_rsp_if.source rsp
);
   localparam int AW = nss_pkg::AddrWidth;
   localparam int CW = nss_pkg::CountWidth;

   nss_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [4:0] step_ff, step_in;

   // query operands
   logic signed [24:0] qx_ff, qz_ff;
   logic signed [24:0] ax_ff, az_ff, dx_ff, dz_ff, wx_ff, wz_ff;
   logic signed [49:0] px1_ff, px2_ff, pn1_ff, pn2_ff;
   logic [50:0] l2_ff;
   logic signed [51:0] num_ff;
   logic [51:0] rem_ff;
   logic [16:0] t_ff;
   logic signed [42:0] mx_ff, mz_ff;
   logic signed [25:0] nx_ff, nz_ff;
   logic [49:0] esx_ff, esz_ff;
   logic found_ff;
   logic [49:0] bd_ff;
   logic [16:0] bt_ff;
   logic signed [23:0] bx_ff, bz_ff;
   logic [7:0] bi_ff;

   // response register
   logic rv_ff;
   logic [2:0] rs_ff;
   logic [24:0] rd_ff;

   logic wr_en;
   logic [nss_pkg::PointWidth-1:0] wr_s, wr_e, rd_s, rd_e;
   logic [AW-1:0] wr_addr, rd_addr;

   nss_pkg::root_req_type  rreq;
   nss_pkg::root_stat_type rstat;

   nss_ram #(.Width(nss_pkg::PointWidth), .Depth(nss_pkg::MaxSegments)) u_start (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_s),
      .rd_addr(rd_addr), .rd_data(rd_s));
   nss_ram #(.Width(nss_pkg::PointWidth), .Depth(nss_pkg::MaxSegments)) u_end (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_e),
      .rd_addr(rd_addr), .rd_data(rd_e));
   nss_root u_root (.clock(clock), .reset(reset), .req(rreq), .stat(rstat));

   logic accept;
   logic full;
   assign accept  = req.valid && req.ready;
   assign full    = (count_ff >= CW'(nss_pkg::MaxSegments));
   assign wr_en   = accept && (nss_pkg::op_type'(req.op) == nss_pkg::OP_APPEND) && !full;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_s    = {req.start_z, req.start_x};
   assign wr_e    = {req.end_z, req.end_x};
   assign rd_addr = idx_ff[AW-1:0];
   assign req.ready = (state_ff == nss_pkg::S_IDLE) && !rv_ff;

   // restoring divide step
   logic [52:0] div_sh;
   assign div_sh = {rem_ff, 1'b0};

   // t clamps (or the segment is degenerate): no quotient bits needed
   logic div_skip;
   assign div_skip = (step_ff == 5'd16) &&
                     ((l2_ff == '0) || (num_ff <= 0) || ($unsigned(num_ff) >= 52'(l2_ff)));

   // error to the query point, squared
   logic signed [25:0] ex_w, ez_w;
   logic signed [51:0] ex_sq, ez_sq;
   assign ex_w  = nx_ff - 26'(qx_ff);
   assign ez_w  = nz_ff - 26'(qz_ff);
   assign ex_sq = ex_w * ex_w;
   assign ez_sq = ez_w * ez_w;

   logic [49:0] dsum;
   assign dsum = esx_ff + esz_ff;

   // strict less-than keeps the earlier segment on a tie
   logic better;
   assign better = !found_ff || (dsum < bd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nss_pkg::S_IDLE:
            if (accept && nss_pkg::op_type'(req.op) == nss_pkg::OP_QUERY && count_ff != '0)
               state_in = nss_pkg::S_READ;
         nss_pkg::S_READ: state_in = nss_pkg::S_DIFF;
         nss_pkg::S_DIFF: state_in = nss_pkg::S_PROD;
         nss_pkg::S_PROD: state_in = nss_pkg::S_SUM;
         nss_pkg::S_SUM:  state_in = nss_pkg::S_DIV;
         nss_pkg::S_DIV:  if (step_ff == 5'd0 || div_skip) state_in = nss_pkg::S_MUL;
         nss_pkg::S_MUL:  state_in = nss_pkg::S_NEAR;
         nss_pkg::S_NEAR: state_in = nss_pkg::S_ESQ;
         nss_pkg::S_ESQ:  state_in = nss_pkg::S_CMP;
         nss_pkg::S_CMP:
            state_in = (idx_ff + CW'(1) >= count_ff) ? nss_pkg::S_ROOT : nss_pkg::S_READ;
         nss_pkg::S_ROOT: if (rstat.done) state_in = nss_pkg::S_RESP;
         nss_pkg::S_RESP: if (!rv_ff) state_in = nss_pkg::S_IDLE;
         default: state_in = nss_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      rreq.start = 1'b0;
      rreq.value = better ? dsum : bd_ff;
      if (accept) begin
         case (nss_pkg::op_type'(req.op))
            nss_pkg::OP_APPEND: if (!full) count_in = count_ff + CW'(1);
            nss_pkg::OP_CLEAR:  count_in = '0;
            nss_pkg::OP_QUERY:  idx_in = '0;
            default: ;
         endcase
      end
      case (state_ff)
         nss_pkg::S_SUM:  step_in = 5'd16;
         nss_pkg::S_DIV:  step_in = (step_ff == 5'd0) ? 5'd0 : step_ff - 5'd1;
         nss_pkg::S_CMP: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) >= count_ff) rreq.start = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nss_pkg::S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         step_ff  <= '0;
         rv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         if (accept) begin
            case (nss_pkg::op_type'(req.op))
               nss_pkg::OP_APPEND: rv_ff <= 1'b1;
               nss_pkg::OP_CLEAR:  rv_ff <= 1'b1;
               nss_pkg::OP_QUERY:  begin
                  found_ff <= 1'b0;
                  if (count_ff == '0) rv_ff <= 1'b1;
               end
               default: ;
            endcase
         end
         if (state_ff == nss_pkg::S_CMP) found_ff <= 1'b1;
         if (state_ff == nss_pkg::S_RESP && !rv_ff) rv_ff <= 1'b1;
      end
      // payload
      if (accept) begin
         qx_ff <= 25'(req.query_x);
         qz_ff <= 25'(req.query_z);
         rd_ff <= '0;
         bx_ff <= '0; bz_ff <= '0; bi_ff <= '0; bt_ff <= '0; bd_ff <= '0;
         case (nss_pkg::op_type'(req.op))
            nss_pkg::OP_APPEND: rs_ff <= full ? nss_pkg::ST_FULL : nss_pkg::ST_LOADED;
            nss_pkg::OP_CLEAR:  rs_ff <= nss_pkg::ST_CLEARED;
            default:            rs_ff <= count_ff == '0 ? nss_pkg::ST_EMPTY
                                                        : nss_pkg::ST_FOUND;
         endcase
      end
      case (state_ff)
         nss_pkg::S_DIFF: begin
            ax_ff <= 25'($signed(rd_s[23:0]));
            az_ff <= 25'($signed(rd_s[47:24]));
            dx_ff <= 25'($signed(rd_e[23:0])) - 25'($signed(rd_s[23:0]));
            dz_ff <= 25'($signed(rd_e[47:24])) - 25'($signed(rd_s[47:24]));
            wx_ff <= qx_ff - 25'($signed(rd_s[23:0]));
            wz_ff <= qz_ff - 25'($signed(rd_s[47:24]));
         end
         nss_pkg::S_PROD: begin
            px1_ff <= dx_ff * dx_ff;
            px2_ff <= dz_ff * dz_ff;
            pn1_ff <= wx_ff * dx_ff;
            pn2_ff <= wz_ff * dz_ff;
         end
         nss_pkg::S_SUM: begin
            l2_ff  <= 51'(px1_ff) + 51'(px2_ff);
            num_ff <= 52'(pn1_ff) + 52'(pn2_ff);
            rem_ff <= 52'(pn1_ff) + 52'(pn2_ff);
            t_ff   <= '0;
         end
         nss_pkg::S_DIV: begin
            if (step_ff == 5'd16) begin
               if (l2_ff == '0 || num_ff <= 0) begin
                  t_ff <= '0;
               end else if (div_skip) begin
                  t_ff <= nss_pkg::TOne;
               end
            end else if (div_sh >= 53'(l2_ff)) begin
               rem_ff <= 52'(div_sh - 53'(l2_ff));
               t_ff   <= {t_ff[15:0], 1'b1};
            end else begin
               rem_ff <= div_sh[51:0];
               t_ff   <= {t_ff[15:0], 1'b0};
            end
         end
         nss_pkg::S_MUL: begin
            mx_ff <= 43'(dx_ff) * $signed({1'b0, t_ff}) + 43'sd32768;
            mz_ff <= 43'(dz_ff) * $signed({1'b0, t_ff}) + 43'sd32768;
         end
         nss_pkg::S_NEAR: begin
            nx_ff <= 26'(ax_ff) + 26'(mx_ff >>> 16);
            nz_ff <= 26'(az_ff) + 26'(mz_ff >>> 16);
         end
         nss_pkg::S_ESQ: begin
            esx_ff <= 50'(ex_sq);
            esz_ff <= 50'(ez_sq);
         end
         nss_pkg::S_CMP: begin
            if (better) begin
               bd_ff <= dsum;
               bt_ff <= t_ff;
               bx_ff <= nx_ff[23:0];
               bz_ff <= nz_ff[23:0];
               bi_ff <= 8'(idx_ff);
            end
         end
         nss_pkg::S_ROOT: if (rstat.done) rd_ff <= rstat.root;
         default: ;
      endcase
   end

   assign rsp.valid         = rv_ff;
   assign rsp.status        = rs_ff;
   assign rsp.near_x        = bx_ff;
   assign rsp.near_z        = bz_ff;
   assign rsp.segment_index = bi_ff;
   assign rsp.t_param       = bt_ff;
   assign rsp.dist_sq       = bd_ff;
   assign rsp.dist_res      = rd_ff;
endmodule

/* hdl/nss_checker.sv */
module nss_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [49:0] rsp_dist_sq,
   input logic [24:0] rsp_dist_res
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request open while result held");
   a_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == nss_pkg::ST_FOUND |->
      50'(rsp_dist_res) * 50'(rsp_dist_res) <= rsp_dist_sq)
      else $error("bad root");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != nss_pkg::ST_FOUND |-> rsp_dist_sq == '0)
      else $error("nonzero field");
endmodule

bind nearest_segment_snap nss_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_dist_sq(rsp.dist_sq), .rsp_dist_res(rsp.dist_res));

/* dv/tb_nearest_segment_snap.sv */
`timescale 1ns / 1ps

module tb_nearest_segment_snap;

   // Cycles with no transfer on either side before the run is declared hung.
   // The worst case is a query over a full table plus receiver stalls, and
   // this limit leaves plenty of margin over it.
   localparam int HangLimit   = 40000;
   localparam int RandomItems = 420;
   localparam int HoldCycles  = 500;   // long receiver back-pressure stretch
   localparam int DrainCycles = 200;   // covers ignored ops still in flight

   typedef struct packed {
      nss_pkg::status_type status;
      logic [23:0]         near_x;
      logic [23:0]         near_z;
      logic [7:0]          seg_idx;
      logic [16:0]         t_frac;
      logic [49:0]         dist_sq;
      logic [24:0]         dist_root;
   } snap_result_type;

   typedef struct packed {
      nss_pkg::op_type     op;
      logic [23:0]         sx, sz, ex, ez, qx, qz;
      logic                typed;   // use res below instead of the predictor
      snap_result_type     res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   nss_req_if req ();
   nss_rsp_if rsp ();

   nearest_segment_snap dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Shadow copy of the segment table kept by the predictor.
   logic signed [23:0] seg_ax [nss_pkg::MaxSegments];
   logic signed [23:0] seg_az [nss_pkg::MaxSegments];
   logic signed [23:0] seg_bx [nss_pkg::MaxSegments];
   logic signed [23:0] seg_bz [nss_pkg::MaxSegments];
   int                 seg_count = 0;

   snap_result_type pending_snaps [$];
   stim_row_type    dir_rows [$];
   int  errors    = 0;
   int  idle_run  = 0;
   bit  send_burst = 0;
   bit  recv_burst = 0;

   function automatic void add_row(stim_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic snap_result_type blank_result(nss_pkg::status_type s);
      snap_result_type r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   function automatic longint floor_root(longint v);
      longint res;
      longint bit_w;
      res = 0;
      bit_w = longint'(1) << 50;
      while (bit_w > v)
         bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Updates the shadow table and returns the result the block should give.
   function automatic snap_result_type snap_predict(nss_pkg::op_type op,
                                                    logic signed [23:0] sx,
                                                    logic signed [23:0] sz,
                                                    logic signed [23:0] ex,
                                                    logic signed [23:0] ez,
                                                    logic signed [23:0] qx,
                                                    logic signed [23:0] qz);
      snap_result_type r;
      longint ax, az, dx, dz, l2, num, rem, t, px, pz, ddx, ddz, d;
      longint best_d, best_t, best_x, best_z;
      int best_i;
      r = blank_result(nss_pkg::ST_LOADED);
      best_d = 0; best_t = 0; best_x = 0; best_z = 0; best_i = 0;
      case (op)
         nss_pkg::OP_APPEND: begin
            if (seg_count >= nss_pkg::MaxSegments) begin
               r.status = nss_pkg::ST_FULL;
            end else begin
               seg_ax[seg_count] = sx; seg_az[seg_count] = sz;
               seg_bx[seg_count] = ex; seg_bz[seg_count] = ez;
               seg_count++;
            end
         end
         nss_pkg::OP_CLEAR: begin
            seg_count = 0;
            r.status = nss_pkg::ST_CLEARED;
         end
         nss_pkg::OP_QUERY: begin
            if (seg_count == 0) begin
               r.status = nss_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < seg_count; i++) begin
                  ax = longint'(seg_ax[i]);
                  az = longint'(seg_az[i]);
                  dx = longint'(seg_bx[i]) - ax;
                  dz = longint'(seg_bz[i]) - az;
                  l2 = dx * dx + dz * dz;
                  num = (longint'(qx) - ax) * dx + (longint'(qz) - az) * dz;
                  if (l2 == 0 || num <= 0) begin
                     t = 0;
                  end else if (num >= l2) begin
                     t = 65536;
                  end else begin
                     // restoring division keeps num*65536 from overflowing
                     rem = num;
                     t = 0;
                     for (int k = 0; k < 16; k++) begin
                        rem = rem << 1;
                        t = t << 1;
                        if (rem >= l2) begin
                           rem = rem - l2;
                           t = t | 1;
                        end
                     end
                  end
                  px = ax + ((dx * t + 32768) >>> 16);
                  pz = az + ((dz * t + 32768) >>> 16);
                  ddx = px - longint'(qx);
                  ddz = pz - longint'(qz);
                  d = ddx * ddx + ddz * ddz;
                  // strict less-than: earlier segment keeps a tie
                  if (i == 0 || d < best_d) begin
                     best_d = d; best_t = t; best_x = px; best_z = pz; best_i = i;
                  end
               end
               r.status    = nss_pkg::ST_FOUND;
               r.near_x    = 24'(best_x);
               r.near_z    = 24'(best_z);
               r.seg_idx   = 8'(best_i);
               r.t_frac    = 17'(best_t);
               r.dist_sq   = 50'(best_d);
               r.dist_root = 25'(floor_root(best_d));
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // One request transfer: idle gap, then hold valid until ready.
   task automatic send_item(stim_row_type row);
      int gap;
      snap_result_type r;
      if ($urandom_range(0, 39) == 0)
         send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.op      <= row.op;
      req.start_x <= row.sx;
      req.start_z <= row.sz;
      req.end_x   <= row.ex;
      req.end_z   <= row.ez;
      req.query_x <= row.qx;
      req.query_z <= row.qz;
      do @(posedge clock); while (!req.ready);
      r = snap_predict(row.op, row.sx, row.sz, row.ex, row.ez, row.qx, row.qz);
      if (row.op != nss_pkg::OP_NONE)
         pending_snaps.insert(pending_snaps.size(), row.typed ? row.res : r);
   endtask

   function automatic stim_row_type mk_row(nss_pkg::op_type op, logic [23:0] sx,
                                           logic [23:0] sz, logic [23:0] ex,
                                           logic [23:0] ez, logic [23:0] qx,
                                           logic [23:0] qz);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.sx = sx; row.sz = sz; row.ex = ex; row.ez = ez; row.qx = qx; row.qz = qz;
      return row;
   endfunction

   function automatic stim_row_type mk_typed(stim_row_type row, snap_result_type res);
      row.typed = 1'b1;
      row.res = res;
      return row;
   endfunction

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 4000)) - 24'd2000;
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($urandom_range(0, 262143)) - 24'd131072;
      endcase
   endfunction

   // Sender: directed table, table fill to overflow, then random sequences.
   initial begin
      stim_row_type row;
      snap_result_type hit;
      int n_items;
      int n_seg;
      int pick;
      logic [23:0] ax, az;

      reset       = 1'b1;
      req.valid   <= 1'b0;
      req.op      <= nss_pkg::OP_NONE;
      req.start_x <= '0; req.start_z <= '0;
      req.end_x   <= '0; req.end_z   <= '0;
      req.query_x <= '0; req.query_z <= '0;

      // unit segment along x, query above its middle: t = 0.5, 1.0 units away
      hit = blank_result(nss_pkg::ST_FOUND);
      hit.near_x = 24'd128; hit.t_frac = 17'd32768;
      hit.dist_sq = 50'd65536; hit.dist_root = 25'd256;

      add_row(mk_typed(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 5, 5),
                       blank_result(nss_pkg::ST_EMPTY)));
      add_row(mk_row(nss_pkg::OP_NONE, 24'hFFFFFF, 0, 24'hFFFFFF, 0, 24'hFFFFFF, 0));
      add_row(mk_typed(mk_row(nss_pkg::OP_APPEND, 0, 0, 256, 0, 0, 0),
                       blank_result(nss_pkg::ST_LOADED)));
      add_row(mk_typed(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 128, 256), hit));
      // zero-length segment
      add_row(mk_typed(mk_row(nss_pkg::OP_APPEND, 512, 512, 512, 512, 0, 0),
                       blank_result(nss_pkg::ST_LOADED)));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 600, 600));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 512, 512));
      // duplicate of the first segment: tie goes to the earlier one
      add_row(mk_row(nss_pkg::OP_APPEND, 0, 0, 256, 0, 0, 0));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, -24'd100, 50));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 1000, 10));
      add_row(mk_row(nss_pkg::OP_APPEND, 24'h800000, 24'h800000,
                     24'h7FFFFF, 24'h7FFFFF, 0, 0));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 24'h800000, 24'h7FFFFF));
      add_row(mk_row(nss_pkg::OP_APPEND, 24'h7FFFFF, 24'h800000,
                     24'h800000, 24'h7FFFFF, 0, 0));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF));
      add_row(mk_typed(mk_row(nss_pkg::OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF),
                       blank_result(nss_pkg::ST_CLEARED)));
      add_row(mk_typed(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0),
                       blank_result(nss_pkg::ST_EMPTY)));
      // largest distance: point at one corner, query at the opposite one
      add_row(mk_row(nss_pkg::OP_APPEND, 24'h800000, 24'h800000,
                     24'h800000, 24'h800000, 0, 0));
      add_row(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF));
      add_row(mk_typed(mk_row(nss_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0),
                       blank_result(nss_pkg::ST_CLEARED)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i]);

      // fill the table, then one append too many and a query over all 256
      for (int i = 0; i < nss_pkg::MaxSegments; i++)
         send_item(mk_row(nss_pkg::OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), 0, 0));
      send_item(mk_typed(mk_row(nss_pkg::OP_APPEND, 1, 1, 2, 2, 0, 0),
                         blank_result(nss_pkg::ST_FULL)));
      send_item(mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, rand_coord(), rand_coord()));
      send_item(mk_row(nss_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));

      // random part: mostly clear / appends / queries near stored segments
      n_items = 0;
      while (n_items < RandomItems) begin
         if ($urandom_range(0, 99) < 8) begin
            row = mk_row(nss_pkg::op_type'($urandom_range(0, 3)), 24'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom));
            if (row.op == nss_pkg::OP_APPEND && seg_count >= 48)
               row.op = nss_pkg::OP_QUERY;   // keep tables short so queries stay quick
            send_item(row);
            if (row.op != nss_pkg::OP_NONE)
               n_items++;
         end else begin
            send_item(mk_row(nss_pkg::OP_CLEAR, 24'($urandom), 0, 0, 0, 0, 0));
            n_seg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < n_seg; i++) begin
               ax = rand_coord();
               az = rand_coord();
               case ($urandom_range(0, 5))
                  0:       row = mk_row(nss_pkg::OP_APPEND, ax, az, ax, az, 0, 0);
                  1:       row = mk_row(nss_pkg::OP_APPEND, ax, az, rand_coord(),
                                        rand_coord(), 0, 0);
                  default: row = mk_row(nss_pkg::OP_APPEND, ax, az,
                                        ax + 24'($urandom_range(0, 8192)) - 24'd4096,
                                        az + 24'($urandom_range(0, 8192)) - 24'd4096, 0, 0);
               endcase
               send_item(row);
            end
            n_items += 1 + n_seg;
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(0, seg_count - 1);
               if ($urandom_range(0, 3) == 0)
                  row = mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0, rand_coord(), rand_coord());
               else
                  row = mk_row(nss_pkg::OP_QUERY, 0, 0, 0, 0,
                               seg_ax[pick] + 24'($urandom_range(0, 4096)) - 24'd2048,
                               seg_bz[pick] + 24'($urandom_range(0, 4096)) - 24'd2048);
               send_item(row);
               n_items++;
            end
         end
      end
      req.valid <= 1'b0;

      while (pending_snaps.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Receiver: random ready gaps, bursts of full rate, and one long hold-off
   // so the block backs up and stalls the request side.
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0)
            recv_burst = !recv_burst;
         gap = recv_burst ? 0 : $urandom_range(0, 18);
         if (taken == 30)
            gap = HoldCycles;
         repeat (gap) begin
            rsp.ready <= 1'b0;
            @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         taken++;
      end
   end

   task automatic report_field(string name, longint want, longint got);
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
   endtask

   // Result checker: each transfer against the oldest pending expectation.
   always @(posedge clock) begin
      snap_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_snaps.size() == 0) begin
            $display("%0t unexpected result: expected none actual status %0d",
                     $time, rsp.status);
            errors++;
         end else begin
            want = pending_snaps.pop_front();
            if (rsp.status !== want.status)
               report_field("status", want.status, rsp.status);
            if (rsp.near_x !== want.near_x)
               report_field("near_x", $signed(want.near_x), rsp.near_x);
            if (rsp.near_z !== want.near_z)
               report_field("near_z", $signed(want.near_z), rsp.near_z);
            if (rsp.segment_index !== want.seg_idx)
               report_field("segment_index", want.seg_idx, rsp.segment_index);
            if (rsp.t_param !== want.t_frac)
               report_field("t_param", want.t_frac, rsp.t_param);
            if (rsp.dist_sq !== want.dist_sq)
               report_field("dist_sq", want.dist_sq, rsp.dist_sq);
            if (rsp.dist_res !== want.dist_root)
               report_field("dist_res", want.dist_root, rsp.dist_res);
         end
      end
   end

   // Hang watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_run <= 0;
      end else if (idle_run >= HangLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

endmodule

/* files.f */
hdl/nss_pkg.sv
hdl/nss_if.sv
hdl/nss_ram.sv
hdl/nss_root.sv
hdl/nearest_segment_snap.sv
hdl/nss_checker.sv
dv/tb_nearest_segment_snap.sv
